### rtl/core/dtpc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtpc_pkg
// Types, register indexes and fixed-point constants shared by the depth to
// colored point cloud block.
// ----------------------------------------------------------------------------
package dtpc_pkg;

  localparam int MAX_WIDTH  = 4096;
  localparam int MAX_HEIGHT = 4096;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_HEIGHT);

  // pixel position in Q.8, wide enough for any frame size up to 65536
  localparam int POS_W      = 24;
  localparam int PROD1_W    = POS_W + 24;
  localparam int T_W        = PROD1_W - 8;
  localparam int T_LO_W     = T_W / 2;
  localparam int T_HI_W     = T_W - T_LO_W;
  localparam int PP_LO_W    = T_LO_W + 24;
  localparam int PP_HI_W    = T_HI_W + 24;
  localparam int SUM_W      = T_W + 24 + 1;
  localparam int R_W        = SUM_W - 24;

  localparam int CNT_W      = 25;
  localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

  localparam logic [23:0] Z_SAT      = 24'hFFFFFF;
  localparam logic [23:0] ZFIX_LOW   = 24'd6554;
  localparam logic [23:0] ZFIX_HIGH  = 24'd163840;
  localparam logic [R_W-1:0] POS_LIM = R_W'(24'd8388607);
  localparam logic [R_W-1:0] NEG_LIM = R_W'(24'd8388608);

  // configuration register indexes
  localparam int CFG_IDX_W = 4;
  localparam logic [CFG_IDX_W-1:0] REG_USE_MASK    = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_Z_SCALE     = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_Z_MIN       = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_Z_MAX       = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_INV_FOCAL_X = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_INV_FOCAL_Y = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_X    = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y    = 4'd7;

  localparam int Q_DEPTH = 2;
  localparam int Q_AW    = $clog2(Q_DEPTH);

  typedef struct packed {
    logic        use_mask;
    logic [23:0] z_scale;
    logic [23:0] z_min;
    logic [23:0] z_max;
    logic [23:0] inv_focal_x;
    logic [23:0] inv_focal_y;
    logic [19:0] center_x;
    logic [19:0] center_y;
  } cfg_t;

  typedef struct packed {
    logic [15:0] depth_code;
    logic [7:0]  mask_value;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic        start_of_frame;
    logic        end_of_row;
    logic        end_of_frame;
  } pixel_t;

  typedef struct packed {
    logic              point_valid;
    logic              frame_done;
    logic [CNT_W-1:0]  point_count;
    logic signed [23:0] x_pos;
    logic signed [23:0] y_pos;
    logic [23:0]       z_depth;
    logic [7:0]        point_red;
    logic [7:0]        point_green;
    logic [7:0]        point_blue;
  } point_t;

  // classified pixel handed from front to back
  typedef struct packed {
    logic             keep;
    logic             eof;
    logic [CNT_W-1:0] count;
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    logic [23:0]      z;
    logic [7:0]       red;
    logic [7:0]       green;
    logic [7:0]       blue;
  } entry_t;

endpackage

### rtl/core/dtpc_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtpc_if
// Valid/ready channels for pixel words and point words.
// ----------------------------------------------------------------------------
interface dtpc_pixel_if;
  logic             valid;
  logic             ready;
  dtpc_pkg::pixel_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface dtpc_point_if;
  logic             valid;
  logic             ready;
  dtpc_pkg::point_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### rtl/core/depth_to_colored_point_cloud.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// depth_to_colored_point_cloud
// Pinhole deprojection of a masked depth pixel stream into colored points.
//
//   channel  dir  handshake      word
//   in_ch    in   valid/ready    pixel_t: depth, mask, RGB, frame/row markers
//   out_ch   out  valid/ready    point_t: flags, count, X/Y/Z, RGB
//   cfg_*    in   cfg_we only    register index and 24-bit data
//
// The front captures a pixel and does the Z multiply, then the gate and count
// update, before it takes the next pixel. A pixel with a result passes a
// 2-entry queue to the back, which pops it, does the focal multiply and the Z
// partial products, then combines and saturates into the output register.
// Synchronous reset clears counters, queue and output valid and loads register
// defaults. A stalled output holds the back; a full queue holds the front.
// ----------------------------------------------------------------------------
module depth_to_colored_point_cloud (
  input  logic                           clk,
  input  logic                           rst_n,
  dtpc_pixel_if.sink                     in_ch,
  dtpc_point_if.source                   out_ch,
  input  logic                           cfg_we,
  input  logic [dtpc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [23:0]                    cfg_data
);
  import dtpc_pkg::*;

  cfg_t   cfg_r, cfg_nxt;
  logic   q_push, q_full, q_pop, q_not_empty;
  entry_t q_wdata, q_rdata;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_USE_MASK:    cfg_nxt.use_mask    = cfg_data[0];
        REG_Z_SCALE:     cfg_nxt.z_scale     = cfg_data;
        REG_Z_MIN:       cfg_nxt.z_min       = cfg_data;
        REG_Z_MAX:       cfg_nxt.z_max       = cfg_data;
        REG_INV_FOCAL_X: cfg_nxt.inv_focal_x = cfg_data;
        REG_INV_FOCAL_Y: cfg_nxt.inv_focal_y = cfg_data;
        REG_CENTER_X:    cfg_nxt.center_x    = cfg_data[19:0];
        REG_CENTER_Y:    cfg_nxt.center_y    = cfg_data[19:0];
        default:         cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.use_mask    <= 1'b1;
      cfg_r.z_scale     <= 24'd16777;
      cfg_r.z_min       <= 24'd0;
      cfg_r.z_max       <= 24'd163840;
      cfg_r.inv_focal_x <= 24'd27962;
      cfg_r.inv_focal_y <= 24'd27962;
      cfg_r.center_x    <= 20'd81920;
      cfg_r.center_y    <= 20'd61440;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  dtpc_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg_r),
    .in_ch  (in_ch),
    .q_push (q_push),
    .q_data (q_wdata),
    .q_full (q_full)
  );

  dtpc_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .pop_data  (q_rdata)
  );

  dtpc_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg_r),
    .q_not_empty (q_not_empty),
    .q_data      (q_rdata),
    .q_pop       (q_pop),
    .out_ch      (out_ch)
  );

endmodule

### rtl/core/dtpc_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtpc_queue
// Short FIFO of classified pixels between front and back.
// ----------------------------------------------------------------------------
module dtpc_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  dtpc_pkg::entry_t  push_data,
  output logic              full,
  input  logic              pop,
  output logic              not_empty,
  output dtpc_pkg::entry_t  pop_data
);
  import dtpc_pkg::*;

  entry_t               mem_r [Q_DEPTH];
  logic [Q_AW-1:0]      wr_ptr_r, wr_ptr_nxt;
  logic [Q_AW-1:0]      rd_ptr_r, rd_ptr_nxt;
  logic [Q_AW:0]        fill_r, fill_nxt;
  logic                 do_push, do_pop;

  assign full      = (fill_r == (Q_AW+1)'(Q_DEPTH));
  assign not_empty = (fill_r != '0);
  assign pop_data  = mem_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    fill_nxt   = fill_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == Q_AW'(Q_DEPTH-1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == Q_AW'(Q_DEPTH-1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      fill_nxt = fill_r + 1'b1;
    end else if (do_pop && !do_push) begin
      fill_nxt = fill_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

### rtl/core/dtpc_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtpc_front
// Accepts pixels, tracks column/row/count, computes Z and the keep gate.
// ----------------------------------------------------------------------------
module dtpc_front (
  input  logic              clk,
  input  logic              rst_n,
  input  dtpc_pkg::cfg_t    cfg,
  dtpc_pixel_if.sink        in_ch,
  output logic              q_push,
  output dtpc_pkg::entry_t  q_data,
  input  logic              q_full
);
  import dtpc_pkg::*;

  localparam logic F_IDLE  = 1'b0;
  localparam logic F_CLASS = 1'b1;

  logic             fs_r, fs_nxt;
  logic [COL_W-1:0] col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic [CNT_W-1:0] kept_r, kept_nxt;

  // captured pixel
  pixel_t           px_r;
  logic [COL_W-1:0] pcol_r;
  logic [ROW_W-1:0] prow_r;
  logic [CNT_W-1:0] base_cnt_r;
  logic [39:0]      zprod_r;

  logic             accept;
  logic [COL_W-1:0] col_base;
  logic [ROW_W-1:0] row_base;
  logic [31:0]      zfull;
  logic [23:0]      z;
  logic             keep;
  logic [CNT_W-1:0] cnt_new;
  logic             need_push;

  assign in_ch.ready = (fs_r == F_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;

  assign col_base = in_ch.data.start_of_frame ? '0 : col_r;
  assign row_base = in_ch.data.start_of_frame ? '0 : row_r;

  // round Q16.24 to Q16.16, then saturate to Q8.16
  assign zfull = 32'((zprod_r + 40'd128) >> 8);
  assign z     = (zfull > 32'(Z_SAT)) ? Z_SAT : zfull[23:0];

  always_comb begin
    keep = (px_r.depth_code != '0);
    if (cfg.use_mask) begin
      keep = keep && (px_r.mask_value != '0) && (z > cfg.z_min) && (z < cfg.z_max);
    end else begin
      keep = keep && (z >= ZFIX_LOW) && (z < ZFIX_HIGH);
    end
  end

  assign cnt_new   = (keep && base_cnt_r < COUNT_MAX) ? base_cnt_r + 1'b1 : base_cnt_r;
  assign need_push = keep || px_r.end_of_frame;

  assign q_push = (fs_r == F_CLASS) && need_push;
  always_comb begin
    q_data.keep  = keep;
    q_data.eof   = px_r.end_of_frame;
    q_data.count = cnt_new;
    q_data.col   = pcol_r;
    q_data.row   = prow_r;
    q_data.z     = z;
    q_data.red   = px_r.red;
    q_data.green = px_r.green;
    q_data.blue  = px_r.blue;
  end

  always_comb begin
    fs_nxt   = fs_r;
    col_nxt  = col_r;
    row_nxt  = row_r;
    kept_nxt = kept_r;
    unique case (fs_r)
      F_IDLE: begin
        if (accept) begin
          fs_nxt = F_CLASS;
          priority if (in_ch.data.end_of_frame) begin
            col_nxt = '0;
            row_nxt = '0;
          end else if (in_ch.data.end_of_row) begin
            col_nxt = '0;
            row_nxt = (row_base < ROW_W'(MAX_HEIGHT-1)) ? row_base + 1'b1 : row_base;
          end else begin
            col_nxt = (col_base < COL_W'(MAX_WIDTH-1)) ? col_base + 1'b1 : col_base;
            row_nxt = row_base;
          end
        end
      end
      F_CLASS: begin
        // hold until the queue has room for the word
        if (!need_push || !q_full) begin
          fs_nxt   = F_IDLE;
          kept_nxt = px_r.end_of_frame ? '0 : cnt_new;
        end
      end
      default: fs_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fs_r   <= F_IDLE;
      col_r  <= '0;
      row_r  <= '0;
      kept_r <= '0;
    end else begin
      fs_r   <= fs_nxt;
      col_r  <= col_nxt;
      row_r  <= row_nxt;
      kept_r <= kept_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      px_r       <= in_ch.data;
      pcol_r     <= col_base;
      prow_r     <= row_base;
      base_cnt_r <= in_ch.data.start_of_frame ? '0 : kept_r;
      zprod_r    <= 40'(in_ch.data.depth_code) * 40'(cfg.z_scale);
    end
  end

endmodule

### rtl/core/dtpc_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtpc_back
// Deprojects classified pixels to X/Y and drives the point output register.
// ----------------------------------------------------------------------------
module dtpc_back (
  input  logic              clk,
  input  logic              rst_n,
  input  dtpc_pkg::cfg_t    cfg,
  input  logic              q_not_empty,
  input  dtpc_pkg::entry_t  q_data,
  output logic              q_pop,
  dtpc_point_if.source      out_ch
);
  import dtpc_pkg::*;

  localparam logic [1:0] B_IDLE = 2'd0;
  localparam logic [1:0] B_MUL1 = 2'd1;
  localparam logic [1:0] B_MUL2 = 2'd2;
  localparam logic [1:0] B_FIN  = 2'd3;

  logic [1:0]         bs_r, bs_nxt;
  logic               ovalid_r, ovalid_nxt;
  point_t             odata_r;

  entry_t             ent_r;
  logic               neg_x_r, neg_y_r;
  logic [PROD1_W-1:0] p1x_r, p1y_r;
  logic [PP_LO_W-1:0] plx_r, ply_r;
  logic [PP_HI_W-1:0] phx_r, phy_r;

  logic [POS_W-1:0]   pos_x, pos_y, cx, cy, mag_x, mag_y;
  logic [T_W-1:0]     t_x, t_y;
  logic [R_W-1:0]     r_x, r_y;
  logic [23:0]        res_x, res_y;
  logic               out_free;
  logic               load_out;

  assign out_free = !ovalid_r || out_ch.ready;
  assign q_pop    = (bs_r == B_IDLE) && q_not_empty;
  assign load_out = (bs_r == B_FIN) && out_free;

  assign pos_x = POS_W'({ent_r.col, 8'b0});
  assign pos_y = POS_W'({ent_r.row, 8'b0});
  assign cx    = POS_W'(cfg.center_x);
  assign cy    = POS_W'(cfg.center_y);
  assign mag_x = (pos_x >= cx) ? pos_x - cx : cx - pos_x;
  assign mag_y = (pos_y >= cy) ? pos_y - cy : cy - pos_y;

  assign t_x = T_W'((p1x_r + PROD1_W'(128)) >> 8);
  assign t_y = T_W'((p1y_r + PROD1_W'(128)) >> 8);

  function automatic logic [R_W-1:0] combine(input logic [PP_HI_W-1:0] ph,
                                             input logic [PP_LO_W-1:0] pl);
    logic [SUM_W-1:0] s;
    s = (SUM_W'(ph) << T_LO_W) + SUM_W'(pl) + (SUM_W'(1) << 23);
    return R_W'(s >> 24);
  endfunction

  // saturate magnitude, then apply the sign
  function automatic logic [23:0] signed_sat(input logic [R_W-1:0] r, input logic neg);
    logic [23:0] m;
    if (neg) begin
      m = (r > NEG_LIM) ? NEG_LIM[23:0] : r[23:0];
      return 24'(-m);
    end
    return (r > POS_LIM) ? POS_LIM[23:0] : r[23:0];
  endfunction

  assign r_x   = combine(phx_r, plx_r);
  assign r_y   = combine(phy_r, ply_r);
  assign res_x = signed_sat(r_x, neg_x_r);
  assign res_y = signed_sat(r_y, neg_y_r);

  assign out_ch.valid = ovalid_r;
  assign out_ch.data  = odata_r;

  always_comb begin
    bs_nxt     = bs_r;
    ovalid_nxt = ovalid_r;
    if (ovalid_r && out_ch.ready) begin
      ovalid_nxt = 1'b0;
    end
    unique case (bs_r)
      B_IDLE: if (q_not_empty) bs_nxt = B_MUL1;
      B_MUL1: bs_nxt = B_MUL2;
      B_MUL2: bs_nxt = B_FIN;
      B_FIN: begin
        if (out_free) begin
          bs_nxt     = B_IDLE;
          ovalid_nxt = 1'b1;
        end
      end
      default: bs_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bs_r     <= B_IDLE;
      ovalid_r <= 1'b0;
    end else begin
      bs_r     <= bs_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      ent_r <= q_data;
    end
    if (bs_r == B_MUL1) begin
      neg_x_r <= (pos_x < cx);
      neg_y_r <= (pos_y < cy);
      p1x_r   <= PROD1_W'(mag_x) * PROD1_W'(cfg.inv_focal_x);
      p1y_r   <= PROD1_W'(mag_y) * PROD1_W'(cfg.inv_focal_y);
    end
    if (bs_r == B_MUL2) begin
      plx_r <= PP_LO_W'(t_x[T_LO_W-1:0]) * PP_LO_W'(ent_r.z);
      ply_r <= PP_LO_W'(t_y[T_LO_W-1:0]) * PP_LO_W'(ent_r.z);
      phx_r <= PP_HI_W'(t_x[T_W-1:T_LO_W]) * PP_HI_W'(ent_r.z);
      phy_r <= PP_HI_W'(t_y[T_W-1:T_LO_W]) * PP_HI_W'(ent_r.z);
    end
    if (load_out) begin
      odata_r.point_valid <= ent_r.keep;
      odata_r.frame_done  <= ent_r.eof;
      odata_r.point_count <= ent_r.count;
      // drop geometry and colour on a frame end without a kept point
      odata_r.x_pos       <= ent_r.keep ? res_x : '0;
      odata_r.y_pos       <= ent_r.keep ? res_y : '0;
      odata_r.z_depth     <= ent_r.keep ? ent_r.z : '0;
      odata_r.point_red   <= ent_r.keep ? ent_r.red : '0;
      odata_r.point_green <= ent_r.keep ? ent_r.green : '0;
      odata_r.point_blue  <= ent_r.keep ? ent_r.blue : '0;
    end
  end

endmodule
